// ----- hw/rtl/ptp_frame_classifier_macros.svh -----
// Assertion macros for the PTP frame classifier.
// Used by the top level; relies on clk and rst_n being in scope.
`ifndef PTP_FRAME_CLASSIFIER_MACROS_SVH
`define PTP_FRAME_CLASSIFIER_MACROS_SVH

// Same-cycle implication, disabled during reset
`define PFC_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define PFC_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/pfc_pkg.sv -----
// Shared types and constants for the PTP frame classifier.
// No dependencies.
`timescale 1ns / 1ps

package pfc_pkg;

    // Frame class codes
    typedef enum logic [1:0] {
        CLASS_NONE = 2'd0,
        CLASS_L2   = 2'd1,
        CLASS_UDP  = 2'd2
    } pfc_class_t;

    // One input item
    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } pfc_item_t;

    // One result item
    typedef struct packed {
        pfc_class_t packet_class;
        logic       dispatch;
    } pfc_result_t;

    // Header constants
    localparam logic [15:0] L2_PTP_TYPE      = 16'h88F7;
    localparam logic [15:0] IPV4_TYPE        = 16'h0800;
    localparam logic [7:0]  UDP_PROTOCOL_NUM = 8'd17;
    localparam logic [15:0] PORT_EVENT       = 16'd319;
    localparam logic [15:0] PORT_GENERAL     = 16'd320;

    // Byte offsets (7-bit counter domain)
    localparam logic [6:0] POS_ETYPE_HI = 7'd12;
    localparam logic [6:0] POS_ETYPE_LO = 7'd13;
    localparam logic [6:0] POS_IHL      = 7'd14;
    localparam logic [6:0] POS_PROTO    = 7'd23;
    localparam logic [6:0] COUNT_MAX    = 7'd127;

endpackage

// ----- hw/rtl/pfc_in_reg.sv -----
// Input register stage for the PTP frame classifier.
// Depends on pfc_pkg.
`timescale 1ns / 1ps

module pfc_in_reg (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  pfc_pkg::pfc_item_t in_item,
    input  logic              advance,
    output logic              held_valid,
    output pfc_pkg::pfc_item_t held_item
);

    logic               valid_reg;
    logic               valid_next;
    pfc_pkg::pfc_item_t item_reg;
    logic               take;

    // Free slot or slot emptying this cycle
    assign in_ready = !valid_reg || advance;
    assign take     = in_valid && in_ready;

    always_comb
    begin
        if (take)
            valid_next = 1'b1;
        else if (advance)
            valid_next = 1'b0;
        else
            valid_next = valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    // Payload, no reset
    always_ff @(posedge clk)
    begin
        if (take)
            item_reg <= in_item;
    end

    assign held_valid = valid_reg;
    assign held_item  = item_reg;

endmodule

// ----- hw/rtl/pfc_hdr_parse.sv -----
// Header field capture and frame classification.
// Depends on pfc_pkg.
`timescale 1ns / 1ps

module pfc_hdr_parse (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 advance,
    input  pfc_pkg::pfc_item_t   item,
    input  logic                 ptp_enable,
    output pfc_pkg::pfc_result_t result
);

    logic [6:0]  byte_count_reg, byte_count_next;
    logic [15:0] eth_type_reg, eth_type_next;
    logic [3:0]  header_words_reg, header_words_next;
    logic [7:0]  ip_protocol_reg, ip_protocol_next;
    logic [15:0] source_port_reg, source_port_next;
    logic [15:0] dest_port_reg, dest_port_next;

    logic [6:0]  pos;
    logic [7:0]  b;
    logic [6:0]  sp;
    logic        src_hit, dst_hit;
    pfc_pkg::pfc_class_t cls;

    assign pos = byte_count_reg;
    assign b   = item.data_byte;

    // IHL nibble, taken on its own byte
    assign header_words_next = (pos == pfc_pkg::POS_IHL) ? b[3:0] : header_words_reg;

    // IHL captured this cycle already places the port bytes
    assign sp = pfc_pkg::POS_IHL + {1'b0, header_words_next, 2'b00};

    // Field capture with this byte applied
    always_comb
    begin
        eth_type_next    = eth_type_reg;
        ip_protocol_next = ip_protocol_reg;
        source_port_next = source_port_reg;
        dest_port_next   = dest_port_reg;

        if (pos == pfc_pkg::POS_ETYPE_HI)
            eth_type_next[15:8] = b;
        if (pos == pfc_pkg::POS_ETYPE_LO)
            eth_type_next[7:0] = b;
        if (pos == pfc_pkg::POS_PROTO)
            ip_protocol_next = b;

        // UDP ports follow the IPv4 header; sp is never below byte 14
        if (pos == sp)
            source_port_next[15:8] = b;
        if (pos == sp + 7'd1)
            source_port_next[7:0] = b;
        if (pos == sp + 7'd2)
            dest_port_next[15:8] = b;
        if (pos == sp + 7'd3)
            dest_port_next[7:0] = b;
    end

    // Saturating byte counter
    assign byte_count_next = (byte_count_reg == pfc_pkg::COUNT_MAX) ?
                             byte_count_reg : byte_count_reg + 7'd1;

    assign src_hit = (source_port_next == pfc_pkg::PORT_EVENT) ||
                     (source_port_next == pfc_pkg::PORT_GENERAL);
    assign dst_hit = (dest_port_next == pfc_pkg::PORT_EVENT) ||
                     (dest_port_next == pfc_pkg::PORT_GENERAL);

    // Classification; length checks written as offset of the last byte
    always_comb
    begin
        cls = pfc_pkg::CLASS_NONE;
        if (ptp_enable && pos >= pfc_pkg::POS_ETYPE_LO)
        begin
            if (eth_type_next == pfc_pkg::L2_PTP_TYPE)
                cls = pfc_pkg::CLASS_L2;
            else if (eth_type_next == pfc_pkg::IPV4_TYPE &&
                     pos >= pfc_pkg::POS_PROTO &&
                     ip_protocol_next == pfc_pkg::UDP_PROTOCOL_NUM &&
                     pos >= sp + 7'd3 &&
                     (src_hit || dst_hit))
                cls = pfc_pkg::CLASS_UDP;
        end
    end

    assign result.packet_class = cls;
    assign result.dispatch     = (cls != pfc_pkg::CLASS_NONE);

    // Frame state; cleared after the last byte
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_count_reg   <= '0;
            eth_type_reg     <= '0;
            header_words_reg <= '0;
            ip_protocol_reg  <= '0;
            source_port_reg  <= '0;
            dest_port_reg    <= '0;
        end
        else if (advance)
        begin
            if (item.last_byte)
            begin
                byte_count_reg   <= '0;
                eth_type_reg     <= '0;
                header_words_reg <= '0;
                ip_protocol_reg  <= '0;
                source_port_reg  <= '0;
                dest_port_reg    <= '0;
            end
            else
            begin
                byte_count_reg   <= byte_count_next;
                eth_type_reg     <= eth_type_next;
                header_words_reg <= header_words_next;
                ip_protocol_reg  <= ip_protocol_next;
                source_port_reg  <= source_port_next;
                dest_port_reg    <= dest_port_next;
            end
        end
    end

endmodule

// ----- hw/rtl/ptp_frame_classifier.sv -----
// Top level of the PTP frame classifier: input stage, header parser, result register.
// Depends on pfc_pkg, pfc_in_reg, pfc_hdr_parse and ptp_frame_classifier_macros.svh.
//
//   channel   dir  contents
//   s_*       in   tdata[7:0] data_byte, tlast last_byte
//   m_*       out  tdata[1:0] packet_class (zero padded to 8), tuser dispatch
//   cfg_*     in   cfg_we strobe, cfg_wdata ptp_enable
//
// One item per cycle sustained unless a last byte waits on a stalled result; each byte
// sits in the input register; its frame state update and classification finish in the
// step into the result register. Only the last byte of a frame yields a result.
// Reset clears the enable, the frame state and both valid flags; no sweep follows.
// A stalled result blocks only a following last byte and any bytes behind it.
`timescale 1ns / 1ps
`include "ptp_frame_classifier_macros.svh"

module ptp_frame_classifier (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] data_byte
    input  logic       s_tlast,   // last_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [1:0] packet_class, [7:2] zero
    output logic       m_tuser,   // [0] dispatch
    input  logic       cfg_we,
    input  logic       cfg_wdata
);

    pfc_pkg::pfc_item_t   in_item;
    pfc_pkg::pfc_item_t   s1_item;
    logic                 s1_valid;
    logic                 s1_adv;
    pfc_pkg::pfc_result_t parse_result;
    pfc_pkg::pfc_result_t result_reg;
    logic                 out_valid_reg, out_valid_next;
    logic                 out_load;
    logic                 ptp_enable_reg;

    assign in_item.data_byte = s_tdata;
    assign in_item.last_byte = s_tlast;

    // Enable register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            ptp_enable_reg <= 1'b0;
        else if (cfg_we)
            ptp_enable_reg <= cfg_wdata;
    end

    pfc_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .advance    (s1_adv),
        .held_valid (s1_valid),
        .held_item  (s1_item)
    );

    // Non-last bytes always move on; a last byte needs a free result slot
    assign s1_adv   = s1_valid && (!s1_item.last_byte || !out_valid_reg || m_tready);
    assign out_load = s1_adv && s1_item.last_byte;

    pfc_hdr_parse u_hdr_parse (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (s1_adv),
        .item       (s1_item),
        .ptp_enable (ptp_enable_reg),
        .result     (parse_result)
    );

    // Result register
    always_comb
    begin
        if (out_load)
            out_valid_next = 1'b1;
        else if (m_tready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            result_reg <= parse_result;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'b0, result_reg.packet_class};
    assign m_tuser  = result_reg.dispatch;

    // Checks
    `PFC_ASSERT_NXT(a_last_fills_out, out_load, m_tvalid, "last byte did not produce a result")
    `PFC_ASSERT_NXT(a_s1_holds, s1_valid && !s1_adv, s1_valid, "input stage dropped an item")
    `PFC_ASSERT_IMP(a_disp_ok, m_tvalid, m_tuser == (m_tdata[1:0] != 2'd0), "dispatch mismatch")
    `PFC_ASSERT_IMP(a_class_legal, m_tvalid, m_tdata[1:0] != 2'd3, "illegal class code")

endmodule
